### design/shabh_pkg.sv
// Shared types and constants for the SHA-256 byte hasher.
// Holds the channel item structs, the controller state type and the round tables.
// No dependencies.
package shabh_pkg;

  typedef struct packed {
    logic       mode;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic        last_word;
  } out_item_t;

  localparam logic MODE_ABSORB = 1'b0;
  localparam logic MODE_FINISH = 1'b1;

  localparam logic [7:0] PAD_MARK     = 8'h80;
  localparam logic [5:0] LEN_POS      = 6'd56;
  localparam logic [5:0] LAST_BYTE    = 6'd63;
  localparam logic [5:0] LAST_ROUND   = 6'd63;
  localparam logic [2:0] LAST_WORD    = 3'd7;
  localparam int unsigned BLK_CNT_W   = 55;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_ADD,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic       load_en;
    logic [7:0] load_byte;
    logic       init_work;
    logic       round_en;
    logic [5:0] round_idx;
    logic       add_en;
    logic       chain_rst;
  } ctrl_t;

  localparam logic [31:0] ROUND_K [0:63] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] H_INIT [0:7] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

endpackage

### design/shabh_msg_sched.sv
// Block buffer and message schedule for the SHA-256 byte hasher.
// Bytes shift in to form sixteen words; during rounds the window expands in place.
// Depends on shabh_pkg.
module shabh_msg_sched (
  input  logic               clk,
  input  shabh_pkg::ctrl_t   ctl,
  output logic [31:0]        w_cur
);

  logic [31:0] w_r [0:15];
  logic [31:0] w_new;
  logic [31:0] sig0;
  logic [31:0] sig1;

  // Sixteen-word window: w_r[0] is the oldest word, used by the current round.
  always_comb begin
    sig0  = {w_r[1][6:0], w_r[1][31:7]} ^ {w_r[1][17:0], w_r[1][31:18]} ^ (w_r[1] >> 3);
    sig1  = {w_r[14][16:0], w_r[14][31:17]} ^ {w_r[14][18:0], w_r[14][31:19]}
            ^ (w_r[14] >> 10);
    w_new = sig1 + w_r[9] + sig0 + w_r[0];
    w_cur = w_r[0];
  end

  always_ff @(posedge clk) begin
    if (ctl.load_en) begin
      for (int i = 0; i < 15; i++) begin
        w_r[i] <= {w_r[i][23:0], w_r[i+1][31:24]};
      end
      w_r[15] <= {w_r[15][23:0], ctl.load_byte};
    end else if (ctl.round_en) begin
      for (int i = 0; i < 15; i++) begin
        w_r[i] <= w_r[i+1];
      end
      w_r[15] <= w_new;
    end
  end

endmodule

### design/shabh_round_core.sv
// Shared SHA-256 round unit with working variables and chaining value.
// One round per enabled cycle; the chaining value is updated in a separate step.
// Depends on shabh_pkg.
module shabh_round_core (
  input  logic               clk,
  input  logic               rst_n,
  input  shabh_pkg::ctrl_t   ctl,
  input  logic [31:0]        w_cur,
  input  logic [2:0]         rd_idx,
  output logic [31:0]        rd_word
);

  logic [31:0] v_r     [0:7];
  logic [31:0] chain_r [0:7];
  logic [31:0] big_s0;
  logic [31:0] big_s1;
  logic [31:0] ch;
  logic [31:0] maj;
  logic [31:0] t1;
  logic [31:0] t2;

  always_comb begin
    big_s1 = {v_r[4][5:0], v_r[4][31:6]} ^ {v_r[4][10:0], v_r[4][31:11]}
             ^ {v_r[4][24:0], v_r[4][31:25]};
    ch     = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
    big_s0 = {v_r[0][1:0], v_r[0][31:2]} ^ {v_r[0][12:0], v_r[0][31:13]}
             ^ {v_r[0][21:0], v_r[0][31:22]};
    maj    = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
    t1     = v_r[7] + big_s1 + ch + shabh_pkg::ROUND_K[ctl.round_idx] + w_cur;
    t2     = big_s0 + maj;
  end

  always_ff @(posedge clk) begin
    if (ctl.init_work) begin
      for (int i = 0; i < 8; i++) begin
        v_r[i] <= chain_r[i];
      end
    end else if (ctl.round_en) begin
      v_r[7] <= v_r[6];
      v_r[6] <= v_r[5];
      v_r[5] <= v_r[4];
      v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2];
      v_r[2] <= v_r[1];
      v_r[1] <= v_r[0];
      v_r[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.chain_rst) begin
      for (int i = 0; i < 8; i++) begin
        chain_r[i] <= shabh_pkg::H_INIT[i];
      end
    end else if (ctl.add_en) begin
      for (int i = 0; i < 8; i++) begin
        chain_r[i] <= chain_r[i] + v_r[i];
      end
    end
  end

  assign rd_word = chain_r[rd_idx];

endmodule

### design/shabh_ctrl.sv
// Sequencer for the SHA-256 byte hasher: byte counting, padding, rounds, output.
// Drives the message schedule and round unit through one control struct.
// Depends on shabh_pkg.
module shabh_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  shabh_pkg::in_item_t  in_item,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [2:0]           out_idx,
  output logic                 out_last,
  output shabh_pkg::ctrl_t     ctl
);

  shabh_pkg::state_t state_r, state_nxt;

  logic [5:0]                      cnt_r, cnt_nxt;
  logic [shabh_pkg::BLK_CNT_W-1:0] blk_r, blk_nxt;
  logic [63:0]                     len_r, len_nxt;
  logic                            first_r, first_nxt;
  logic                            zpad_r, zpad_nxt;
  logic                            final_r, final_nxt;
  logic                            padding_r, padding_nxt;
  logic [5:0]                      rnd_r, rnd_nxt;
  logic [2:0]                      oidx_r, oidx_nxt;

  logic       accept;
  logic       acc_absorb;
  logic       acc_finish;
  logic       out_take;
  logic       in_pad;
  logic       blk_full;
  logic [7:0] pad_byte;

  assign accept     = in_valid && in_ready;
  assign acc_absorb = accept && (in_item.mode == shabh_pkg::MODE_ABSORB);
  assign acc_finish = accept && (in_item.mode == shabh_pkg::MODE_FINISH);
  assign in_pad     = (state_r == shabh_pkg::ST_PAD);
  assign blk_full   = (cnt_r == shabh_pkg::LAST_BYTE);
  assign out_take   = out_valid && out_ready;

  // Pad byte: marker first, zeros up to the length field, then the length.
  always_comb begin
    if (first_r) begin
      pad_byte = shabh_pkg::PAD_MARK;
    end else if (zpad_r || (cnt_r < shabh_pkg::LEN_POS)) begin
      pad_byte = 8'h00;
    end else begin
      pad_byte = len_r[63:56];
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      shabh_pkg::ST_IDLE: begin
        if (acc_finish) begin
          state_nxt = shabh_pkg::ST_PAD;
        end else if (acc_absorb && blk_full) begin
          state_nxt = shabh_pkg::ST_ROUND;
        end
      end
      shabh_pkg::ST_PAD: begin
        if (blk_full) begin
          state_nxt = shabh_pkg::ST_ROUND;
        end
      end
      shabh_pkg::ST_ROUND: begin
        if (rnd_r == shabh_pkg::LAST_ROUND) begin
          state_nxt = shabh_pkg::ST_ADD;
        end
      end
      shabh_pkg::ST_ADD: begin
        if (final_r) begin
          state_nxt = shabh_pkg::ST_OUT;
        end else if (padding_r) begin
          state_nxt = shabh_pkg::ST_PAD;
        end else begin
          state_nxt = shabh_pkg::ST_IDLE;
        end
      end
      shabh_pkg::ST_OUT: begin
        if (out_take && (oidx_r == shabh_pkg::LAST_WORD)) begin
          state_nxt = shabh_pkg::ST_IDLE;
        end
      end
      default: state_nxt = shabh_pkg::ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    in_ready      = (state_r == shabh_pkg::ST_IDLE);
    out_valid     = (state_r == shabh_pkg::ST_OUT);
    out_idx       = oidx_r;
    out_last      = (oidx_r == shabh_pkg::LAST_WORD);
    ctl.load_en   = acc_absorb || in_pad;
    ctl.load_byte = in_pad ? pad_byte : in_item.data_byte;
    ctl.init_work = (acc_absorb || in_pad) && blk_full;
    ctl.round_en  = (state_r == shabh_pkg::ST_ROUND);
    ctl.round_idx = rnd_r;
    ctl.add_en    = (state_r == shabh_pkg::ST_ADD);
    ctl.chain_rst = (state_r == shabh_pkg::ST_OUT) && out_ready
                    && (oidx_r == shabh_pkg::LAST_WORD);
  end

  // Counters and padding bookkeeping.
  always_comb begin
    cnt_nxt     = cnt_r;
    blk_nxt     = blk_r;
    len_nxt     = len_r;
    first_nxt   = first_r;
    zpad_nxt    = zpad_r;
    final_nxt   = final_r;
    padding_nxt = padding_r;
    rnd_nxt     = rnd_r;
    oidx_nxt    = oidx_r;

    if (ctl.load_en) begin
      cnt_nxt = cnt_r + 6'd1;
    end
    if (acc_finish) begin
      len_nxt     = {blk_r, cnt_r, 3'b000};
      blk_nxt     = '0;
      first_nxt   = 1'b1;
      padding_nxt = 1'b1;
    end else if (acc_absorb && blk_full) begin
      blk_nxt = blk_r + shabh_pkg::BLK_CNT_W'(1);
    end
    if (in_pad) begin
      first_nxt = 1'b0;
      if (!first_r && !zpad_r && (cnt_r >= shabh_pkg::LEN_POS)) begin
        len_nxt = {len_r[55:0], 8'h00};
      end
      if (blk_full) begin
        zpad_nxt = 1'b0;
      end else if (first_r) begin
        zpad_nxt = (cnt_r >= shabh_pkg::LEN_POS);
      end
    end
    if (ctl.init_work) begin
      final_nxt = in_pad && !first_r && !zpad_r;
    end
    if (ctl.round_en) begin
      rnd_nxt = rnd_r + 6'd1;
    end
    if (ctl.add_en && final_r) begin
      padding_nxt = 1'b0;
    end
    if (out_take) begin
      oidx_nxt = oidx_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= shabh_pkg::ST_IDLE;
      cnt_r     <= '0;
      blk_r     <= '0;
      first_r   <= 1'b0;
      zpad_r    <= 1'b0;
      final_r   <= 1'b0;
      padding_r <= 1'b0;
      rnd_r     <= '0;
      oidx_r    <= '0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      blk_r     <= blk_nxt;
      first_r   <= first_nxt;
      zpad_r    <= zpad_nxt;
      final_r   <= final_nxt;
      padding_r <= padding_nxt;
      rnd_r     <= rnd_nxt;
      oidx_r    <= oidx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    len_r <= len_nxt;
  end

endmodule

### design/sha256_byte_hasher.sv
// Top level of the SHA-256 byte hasher.
// Instantiates shabh_ctrl, shabh_msg_sched and shabh_round_core; uses shabh_pkg.
//
// This block computes standard SHA-256 over a message that arrives one byte per
// input item. An absorb item (mode 0) carries one byte. Every 64th byte fills a
// block, and the block is then busy: one shared round unit runs the 64 rounds
// one per cycle, and the ST_ADD state then adds the result into the chaining
// value. A finish item (mode 1) feeds the padding bytes through the same byte
// path, one per cycle (64 - n bytes, or 128 - n when n, the bytes already in
// the block, is 56 or more), with a compression after each block it completes.
// The eight digest words then come out as eight result items, word 0 first,
// with last_word set on the eighth. After the eighth word is taken, the
// chaining value is back at its initial value and the block is ready for a new
// message. The input channel is not ready while a compression, padding or
// digest output is in progress. The bit length wraps modulo 2^64.
module sha256_byte_hasher (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  shabh_pkg::in_item_t   in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output shabh_pkg::out_item_t  out_data
);

  shabh_pkg::ctrl_t ctl;
  logic [31:0]      w_cur;
  logic [2:0]       out_idx;
  logic             out_last;
  logic [31:0]      rd_word;

  // Sequencer: byte counting, padding generation and round stepping.
  shabh_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_item   (in_data),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_idx   (out_idx),
    .out_last  (out_last),
    .ctl       (ctl)
  );

  // The block buffer doubles as the message schedule window.
  shabh_msg_sched u_sched (
    .clk   (clk),
    .ctl   (ctl),
    .w_cur (w_cur)
  );

  // Shared round unit holding the working variables and the chaining value.
  shabh_round_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl),
    .w_cur   (w_cur),
    .rd_idx  (out_idx),
    .rd_word (rd_word)
  );

  // Digest words are read straight from the chaining registers.
  assign out_data.digest_word = rd_word;
  assign out_data.last_word   = out_last;

endmodule

### tb/sha256_byte_hasher_test.sv
// Self-checking testbench for the SHA-256 byte hasher, with its own SHA-256 predictor.
// Streams random and directed messages with random idling on both channels.
// Depends on shabh_pkg and sha256_byte_hasher.
`timescale 1ns / 100ps

module sha256_byte_hasher_test;

  // The run ends here at the latest.
  localparam int CYCLE_LIMIT = 400000;
  // Number of input items that each idling phase should roughly carry.
  localparam int PHASE_ITEMS = 120;
  // Quiet stretch long enough to cover any compression still in flight.
  localparam int DRAIN_CYCLES = 200;

  // Round constants and initial chaining value, as published in FIPS 180-4.
  localparam logic [31:0] SHA_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };
  localparam logic [31:0] SHA_IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  // Clock, reset and the two channels. Every input starts at a known value.
  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  shabh_pkg::in_item_t  in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  shabh_pkg::out_item_t out_data;

  // Items waiting to be sent, and digest words still owed by the block.
  shabh_pkg::in_item_t  pending_items[$];
  shabh_pkg::out_item_t digest_words_due[$];

  // Idling percentages, changed by the stimulus process between phases.
  int send_idle_pct = 25;
  int recv_idle_pct = 86;

  int cycle_count = 0;
  int mismatch_count = 0;

  // Predictor state: the partial block, the byte count within it, the bits
  // already compressed and the chaining value.
  logic [7:0]  msg_block [64];
  logic [5:0]  msg_fill;
  logic [63:0] msg_bits;
  logic [31:0] chain_h [8];

  sha256_byte_hasher DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #6 clk = ~clk;

  function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // Back to the start of a message: empty block, zero length, initial chain.
  task automatic clear_hash_state();
    msg_fill = '0;
    msg_bits = '0;
    for (int k = 0; k < 8; k++) chain_h[k] = SHA_IV[k];
  endtask

  // One SHA-256 compression of msg_block into chain_h.
  task automatic compress_block();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] s0, s1, t1, t2;
    for (int i = 0; i < 16; i++) begin
      w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
    end
    for (int i = 16; i < 64; i++) begin
      s0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = s1 + w[i-7] + s0 + w[i-16];
    end
    for (int k = 0; k < 8; k++) v[k] = chain_h[k];
    for (int i = 0; i < 64; i++) begin
      t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + SHA_K[i] + w[i];
      t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6];
      v[6] = v[5];
      v[5] = v[4];
      v[4] = v[3] + t1;
      v[3] = v[2];
      v[2] = v[1];
      v[1] = v[0];
      v[0] = t1 + t2;
    end
    for (int k = 0; k < 8; k++) chain_h[k] += v[k];
  endtask

  // Advances the predicted hash by one accepted item. A finish item pads the
  // message, runs the final one or two compressions and queues the eight
  // digest words that the block must then emit.
  task automatic hash_one_item(input shabh_pkg::in_item_t item);
    logic [63:0]          total_bits;
    int                   pos;
    shabh_pkg::out_item_t word;
    if (item.mode == shabh_pkg::MODE_ABSORB) begin
      msg_block[msg_fill] = item.data_byte;
      msg_fill = msg_fill + 6'd1;
      if (msg_fill == '0) begin
        compress_block();
        msg_bits = msg_bits + 64'd512;
      end
    end else begin
      total_bits = msg_bits + {55'd0, msg_fill, 3'd0};
      pos = int'(msg_fill);
      msg_block[pos] = 8'h80;
      pos++;
      // No room for the length after the marker: close this block first.
      if (pos > 56) begin
        while (pos < 64) begin
          msg_block[pos] = 8'h00;
          pos++;
        end
        compress_block();
        pos = 0;
      end
      while (pos < 56) begin
        msg_block[pos] = 8'h00;
        pos++;
      end
      for (int k = 0; k < 8; k++) msg_block[56 + k] = total_bits[63 - 8*k -: 8];
      compress_block();
      for (int k = 0; k < 8; k++) begin
        word.digest_word = chain_h[k];
        word.last_word   = (k == 7);
        digest_words_due.push_back(word);
      end
      clear_hash_state();
    end
  endtask

  task automatic queue_item(input logic mode, input logic [7:0] data_byte);
    shabh_pkg::in_item_t item;
    item.mode      = mode;
    item.data_byte = data_byte;
    pending_items.push_back(item);
  endtask

  // Queues a message of random bytes closed by a finish item, whose byte
  // is random too since the block must ignore it.
  task automatic queue_message(input int len);
    for (int i = 0; i < len; i++) queue_item(shabh_pkg::MODE_ABSORB, 8'($urandom));
    queue_item(shabh_pkg::MODE_FINISH, 8'($urandom));
  endtask

  // Message lengths lean towards short messages and towards the lengths at
  // which the padding needs a second block or a block boundary is crossed.
  function automatic int pick_msg_len();
    int edge_lens [10] = '{55, 56, 57, 63, 64, 65, 119, 120, 127, 128};
    int r;
    r = $urandom_range(99);
    if (r < 40) return $urandom_range(20);
    if (r < 75) return edge_lens[$urandom_range(9)];
    return $urandom_range(140);
  endfunction

  // Driver. An item is taken at an edge where in_valid and in_ready are both
  // high; the predictor is advanced right there. A new item, or a gap, is
  // chosen only when the channel is free, so valid and payload hold steady
  // while the block stalls.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        hash_one_item(in_data);
      end
      if (!in_valid || in_ready) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data  <= pending_items.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // The receiver stalls at random at the current phase's rate.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Monitor. Each digest word taken from the block is matched against the
  // oldest word still owed, field by field. Only the first ten failures are
  // described; the rest are counted.
  always @(posedge clk) begin
    shabh_pkg::out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (digest_words_due.size() == 0) begin
        if (mismatch_count < 10) begin
          $display("[%0d] unexpected digest word %h last %b", cycle_count,
                   out_data.digest_word, out_data.last_word);
        end
        mismatch_count++;
      end else begin
        want = digest_words_due.pop_front();
        if (out_data.digest_word !== want.digest_word ||
            out_data.last_word !== want.last_word) begin
          if (mismatch_count < 10) begin
            $display("[%0d] digest word: expected %h last %b, got %h last %b",
                     cycle_count, want.digest_word, want.last_word,
                     out_data.digest_word, out_data.last_word);
          end
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: a hung block or a lost digest word ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("sha256_byte_hasher regression: fail");
      $finish;
    end
  end

  // Stimulus: reset, a directed opening, then three phases of random
  // messages with different idling on the two sides, then the drain.
  initial begin
    clear_hash_state();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // The empty message, twice in a row, the second time with a finish byte
    // of all ones to show that the byte of a finish item is ignored.
    queue_item(shabh_pkg::MODE_FINISH, 8'h00);
    queue_item(shabh_pkg::MODE_FINISH, 8'hff);
    // Single-byte messages at both extremes of the byte.
    queue_item(shabh_pkg::MODE_ABSORB, 8'h00);
    queue_item(shabh_pkg::MODE_FINISH, 8'h00);
    queue_item(shabh_pkg::MODE_ABSORB, 8'hff);
    queue_item(shabh_pkg::MODE_FINISH, 8'h5a);
    // The classic "abc" message.
    queue_item(shabh_pkg::MODE_ABSORB, 8'h61);
    queue_item(shabh_pkg::MODE_ABSORB, 8'h62);
    queue_item(shabh_pkg::MODE_ABSORB, 8'h63);
    queue_item(shabh_pkg::MODE_FINISH, 8'h00);
    // Bytes that look like the pad marker or sit next to it.
    queue_item(shabh_pkg::MODE_ABSORB, 8'h80);
    queue_item(shabh_pkg::MODE_ABSORB, 8'h7f);
    queue_item(shabh_pkg::MODE_ABSORB, 8'h01);
    queue_item(shabh_pkg::MODE_ABSORB, 8'hfe);
    queue_item(shabh_pkg::MODE_FINISH, 8'hff);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 25;
          recv_idle_pct = 86;
        end
        1: begin
          send_idle_pct = 86;
          recv_idle_pct = 25;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      while (pending_items.size() < PHASE_ITEMS) queue_message(pick_msg_len());
      while (pending_items.size() != 0) @(posedge clk);
    end

    // Every item sent and every owed digest word received, then a quiet
    // stretch to catch anything extra the block might still emit.
    while (in_valid || digest_words_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && digest_words_due.size() == 0) begin
      $display("sha256_byte_hasher regression: pass");
    end else begin
      $display("sha256_byte_hasher regression: fail");
    end
    $finish;
  end

endmodule

### sha256_byte_hasher.f
design/shabh_pkg.sv
design/shabh_msg_sched.sv
design/shabh_round_core.sv
design/shabh_ctrl.sv
design/sha256_byte_hasher.sv
tb/sha256_byte_hasher_test.sv
